>>> rtl/melody_note_sequencer_macros.svh
// Assertion macros used by the port-level checker of melody_note_sequencer.
// No dependencies; pulled in by `include where assertions are written.
`ifndef MELODY_NOTE_SEQUENCER_MACROS_SVH
`define MELODY_NOTE_SEQUENCER_MACROS_SVH

// Clocked assertion, held off while the synchronous reset is asserted.
`define MSQ_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Same, on the block clock and reset.
`define MSQ_ASSERT(label, prop, msg) `MSQ_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

>>> rtl/msq_pkg.sv
// Types and constants of the melody note sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package msq_pkg;

    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_WRITE = 3'd1;
    localparam logic [2:0] ACT_START = 3'd2;
    localparam logic [2:0] ACT_STOP  = 3'd3;
    localparam logic [2:0] ACT_TONE  = 3'd4;

    localparam logic [15:0] TICKS_PENDING = 16'hFFFF;
    localparam logic [15:0] PERIOD_RESET  = 16'd1000;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  note_address;
        logic [14:0] note_length;
        logic [15:0] note_divider;
        logic [7:0]  start_address;
    } t_in_item;

    typedef struct packed {
        logic        tone_enable;
        logic [15:0] reload_value;
        logic [14:0] compare_value;
        logic        melody_active;
    } t_out_item;

    typedef struct packed {
        logic exec;
        logic load;
        logic out_write;
    } t_msq_cmd;

    typedef struct packed {
        logic need_load;
    } t_msq_sts;

endpackage

>>> rtl/msq_ctrl.sv
// Controller of the melody note sequencer: handshake and load sequencing.
// Depends on msq_pkg.
`timescale 1ns / 1ps

module msq_ctrl import msq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_msq_sts i_sts,
    output t_msq_cmd o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_LOAD
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_ready;
    logic   w_accept;

    // Take an item only when idle and the result slot is free or draining.
    assign w_ready  = (r_state == ST_IDLE) && (!r_out_valid || !i_out_stall);
    assign w_accept = i_in_valid && w_ready;

    always_comb begin
        o_cmd.exec      = w_accept;
        o_cmd.load      = (r_state == ST_LOAD);
        o_cmd.out_write = (w_accept && !i_sts.need_load) || (r_state == ST_LOAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_write) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && i_sts.need_load) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = !w_ready;
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/msq_datapath.sv
// Datapath of the melody note sequencer: note store, melody state, timer settings.
// Depends on msq_pkg; driven by msq_ctrl commands.
`timescale 1ns / 1ps

module msq_datapath import msq_pkg::*; #(
    parameter int NOTE_DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_msq_cmd  i_cmd,
    output t_msq_sts  o_sts,
    input  t_in_item  i_in_data,
    output t_out_item o_out_data
);

    localparam int AW = $clog2(NOTE_DEPTH);
    localparam int RW = AW + 5;
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(NOTE_DEPTH);

    logic [30:0]   r_mem [NOTE_DEPTH];
    logic [30:0]   r_rdata;
    logic [AW-1:0] r_load_addr;
    logic [15:0]   r_rem;
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] r_pend;
    logic          r_tone;
    logic [15:0]   r_period;
    t_out_item     r_out;

    logic [15:0]   n_rem;
    logic [AW-1:0] n_ptr;
    logic [AW-1:0] n_pend;
    logic          n_tone;
    logic [15:0]   n_period;

    logic [AW:0]   w_ptr_inc;
    logic [AW-1:0] w_ptr_next;
    logic [AW-1:0] w_rd_addr;
    logic          w_need_load;
    logic [14:0]   w_ld_len;
    logic [15:0]   w_ld_div;

    // Reduce an 8-bit address modulo the store depth: quotient stays below 16.
    function automatic logic [AW-1:0] f_wrap(input logic [7:0] a);
        logic [RW-1:0] v;
        v = RW'(a);
        for (int k = 3; k >= 0; k--) begin
            if (v >= (RW'(NOTE_DEPTH) << k)) begin
                v = v - (RW'(NOTE_DEPTH) << k);
            end
        end
        return v[AW-1:0];
    endfunction

    assign w_ptr_inc  = {1'b0, r_ptr} + (AW + 1)'(1);
    assign w_ptr_next = (w_ptr_inc == DEPTH_W) ? '0 : w_ptr_inc[AW-1:0];
    assign w_ld_len   = r_rdata[14:0];
    assign w_ld_div   = r_rdata[30:15];

    // A tick needs a store read when a start is pending or the note runs out.
    always_comb begin
        w_need_load = 1'b0;
        w_rd_addr   = w_ptr_next;
        if (i_in_data.action == ACT_TICK) begin
            if (r_rem == TICKS_PENDING) begin
                w_need_load = 1'b1;
                w_rd_addr   = r_pend;
            end else if (r_rem == 16'd1) begin
                w_need_load = 1'b1;
            end
        end
    end

    assign o_sts.need_load = w_need_load;

    always_comb begin
        n_rem    = r_rem;
        n_ptr    = r_ptr;
        n_pend   = r_pend;
        n_tone   = r_tone;
        n_period = r_period;
        if (i_cmd.exec) begin
            unique case (i_in_data.action)
                ACT_TICK: begin
                    if (!w_need_load && (r_rem != 16'd0)) begin
                        n_rem = r_rem - 16'd1;
                    end
                end
                ACT_START: begin
                    n_pend = f_wrap(i_in_data.start_address);
                    n_rem  = TICKS_PENDING;
                end
                ACT_STOP: begin
                    n_rem  = 16'd0;
                    n_tone = 1'b0;
                end
                ACT_TONE: begin
                    n_period = i_in_data.note_divider;
                    n_tone   = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.load) begin
            n_ptr = r_load_addr;
            n_rem = {1'b0, w_ld_len};
            if ((w_ld_len == 15'd0) || (w_ld_div == 16'd0)) begin
                n_tone = 1'b0;
            end else begin
                n_period = w_ld_div;
                n_tone   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem    <= 16'd0;
            r_ptr    <= '0;
            r_pend   <= '0;
            r_tone   <= 1'b0;
            r_period <= PERIOD_RESET;
        end else begin
            r_rem    <= n_rem;
            r_ptr    <= n_ptr;
            r_pend   <= n_pend;
            r_tone   <= n_tone;
            r_period <= n_period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (i_in_data.action == ACT_WRITE)) begin
            r_mem[f_wrap(i_in_data.note_address)] <=
                {i_in_data.note_divider, i_in_data.note_length};
        end
        if (i_cmd.exec) begin
            r_rdata     <= r_mem[w_rd_addr];
            r_load_addr <= w_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_write) begin
            r_out.tone_enable   <= n_tone;
            r_out.reload_value  <= n_period;
            r_out.compare_value <= n_period[15:1];
            r_out.melody_active <= (n_rem != 16'd0);
        end
    end

    assign o_out_data = r_out;

endmodule

>>> rtl/melody_note_sequencer.sv
// Melody note sequencer: a registered result per accepted item; a tick that loads
// a note (melody start or note run out) goes through the load state first.
// Throughput: one item per cycle while the output is not stalled; a note-loading
// tick holds input off in its load state for the registered store read. The next
// item is taken while a result waits if the output register drains in that cycle.
// Reset (sync, active low) clears melody state, period back to 1000; store kept.
`timescale 1ns / 1ps

module melody_note_sequencer import msq_pkg::*; #(
    parameter int NOTE_DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // Command items: tick, write note, start, stop, bare tone.
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    // One result item per command: timer settings after the update.
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_msq_cmd w_cmd;
    t_msq_sts w_sts;

    // Controller: accept items, sequence the note load through its load state, own the
    // output valid flag.
    msq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Datapath: note store memory, countdown, pointer wrap, timer settings
    // and the output register.
    msq_datapath #(
        .NOTE_DEPTH (NOTE_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

>>> rtl/msq_checker.sv
// Port-level checker of melody_note_sequencer, bound to the top level.
// Depends on msq_pkg and melody_note_sequencer_macros.svh.
`timescale 1ns / 1ps
`include "melody_note_sequencer_macros.svh"

module msq_assert import msq_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && !o_in_stall;

    `MSQ_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)), "stalled result changed")
    `MSQ_ASSERT(a_half_period, o_out_valid |-> (o_out_data.compare_value == o_out_data.reload_value[15:1]), "compare is not half of reload")
    `MSQ_ASSERT(a_stop_silent, (w_in_acc && (i_in_data.action == ACT_STOP)) |=> (o_out_valid && !o_out_data.tone_enable && !o_out_data.melody_active), "stop did not silence")
    `MSQ_ASSERT(a_tone_set, (w_in_acc && (i_in_data.action == ACT_TONE)) |=> (o_out_valid && o_out_data.tone_enable && (o_out_data.reload_value == $past(i_in_data.note_divider))), "bare tone not applied")
    `MSQ_ASSERT(a_start_active, (w_in_acc && (i_in_data.action == ACT_START)) |=> (o_out_valid && o_out_data.melody_active), "start did not mark melody active")

endmodule

bind melody_note_sequencer msq_assert u_msq_assert (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

>>> dv/msq_checker.sv
// Checker for melody_note_sequencer: watches both item channels, predicts each
// result from its own copy of the sequencer state and compares field by field.
// Depends on msq_pkg for the item structs and action codes.
`timescale 1ns / 1ps

module msq_checker import msq_pkg::*; #(
    parameter int NOTE_DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_outstanding,
    output int        o_results_checked,
    output int        o_notes_loaded,
    output int        o_melodies_ended
);

    typedef struct packed {
        logic [15:0] divider;
        logic [14:0] length;
    } t_note_entry;

    // Predicted sequencer state.
    t_note_entry note_mem [NOTE_DEPTH];
    logic [15:0] ticks_left;
    int          note_ptr;
    int          start_entry;
    logic        sounding;
    logic [15:0] period;

    // Timer settings still owed by the block, oldest first.
    t_out_item   settings_due [$];

    initial begin
        o_fail_count      = 0;
        o_outstanding     = 0;
        o_results_checked = 0;
        o_notes_loaded    = 0;
        o_melodies_ended  = 0;
    end

    function automatic void load_note(int idx);
        t_note_entry e;
        note_ptr   = idx % NOTE_DEPTH;
        e          = note_mem[note_ptr];
        ticks_left = {1'b0, e.length};
        if (e.length == '0 || e.divider == '0) begin
            sounding = 1'b0;
        end else begin
            period   = e.divider;
            sounding = 1'b1;
        end
        o_notes_loaded++;
        if (e.length == '0) o_melodies_ended++;
    endfunction

    // Advance the predicted state by one item and return the timer view after it.
    function automatic t_out_item apply_command(t_in_item it);
        t_out_item view;
        case (it.action)
            ACT_TICK: begin
                if (ticks_left == TICKS_PENDING) begin
                    load_note(start_entry);
                end else if (ticks_left != '0) begin
                    ticks_left--;
                    if (ticks_left == '0) load_note(note_ptr + 1);
                end
            end
            ACT_WRITE: note_mem[int'(it.note_address) % NOTE_DEPTH] =
                           {it.note_divider, it.note_length};
            ACT_START: begin
                start_entry = int'(it.start_address) % NOTE_DEPTH;
                ticks_left  = TICKS_PENDING;
            end
            ACT_STOP: begin
                ticks_left = '0;
                sounding   = 1'b0;
            end
            ACT_TONE: begin
                period   = it.note_divider;
                sounding = 1'b1;
            end
            default: ;
        endcase
        view.tone_enable   = sounding;
        view.reload_value  = period;
        view.compare_value = period[15:1];
        view.melody_active = (ticks_left != '0);
        return view;
    endfunction

    task automatic report(string field, logic [15:0] want, logic [15:0] got);
        o_fail_count++;
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            ticks_left  = '0;
            note_ptr    = 0;
            start_entry = 0;
            sounding    = 1'b0;
            period      = PERIOD_RESET;
            settings_due.delete();
        end else begin
            // Compare first: a result leaving now belongs to an earlier item.
            if (i_out_valid && !i_out_stall) begin
                if (settings_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result with nothing expected, got %0h", $time, i_out_data);
                end else begin
                    want = settings_due.pop_front();
                    o_results_checked++;
                    if (i_out_data.tone_enable !== want.tone_enable)
                        report("tone_enable", 16'(want.tone_enable),
                               16'(i_out_data.tone_enable));
                    if (i_out_data.reload_value !== want.reload_value)
                        report("reload_value", want.reload_value, i_out_data.reload_value);
                    if (i_out_data.compare_value !== want.compare_value)
                        report("compare_value", 16'(want.compare_value),
                               16'(i_out_data.compare_value));
                    if (i_out_data.melody_active !== want.melody_active)
                        report("melody_active", 16'(want.melody_active),
                               16'(i_out_data.melody_active));
                end
            end
            if (i_in_valid && !i_in_stall) settings_due.push_back(apply_command(i_in_data));
        end
        o_outstanding <= settings_due.size();
    end

endmodule

>>> dv/testbench.sv
// Top of the melody_note_sequencer testbench: clock, reset, command stimulus,
// result back-pressure, watchdog and verdict. Needs msq_pkg, the block and
// msq_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module testbench;
    import msq_pkg::*;

    localparam int  NOTE_DEPTH     = 256;
    localparam int  CLK_PERIOD     = 10;
    localparam int  ITEM_TARGET    = 700;
    localparam int  WATCHDOG_LIMIT = 2000;
    // Action codes the block has no use for; it must leave its state alone.
    localparam logic [2:0] ACT_UNUSED_LO  = 3'd5;
    localparam logic [2:0] ACT_UNUSED_MID = 3'd6;
    localparam logic [2:0] ACT_UNUSED_HI  = 3'd7;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;

    int fail_count, outstanding, results_checked, notes_loaded, melodies_ended;
    int action_count [8];
    int items_sent   = 0;
    int idle_cycles  = 0;
    int stall_left   = 0;
    bit send_burst   = 1'b0;
    bit recv_burst   = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    melody_note_sequencer #(.NOTE_DEPTH(NOTE_DEPTH)) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    msq_checker #(.NOTE_DEPTH(NOTE_DEPTH)) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_in_data        (in_data),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_data       (out_data),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding),
        .o_results_checked(results_checked),
        .o_notes_loaded   (notes_loaded),
        .o_melodies_ended (melodies_ended)
    );

    // Idle length for either side: mostly none or short, now and then long.
    // In a burst stretch there is no idling at all.
    function automatic int idle_len(bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Hold the result side off at random; flip into and out of burst stretches.
    always @(posedge clk) begin
        if ($urandom_range(199) == 0) recv_burst <= !recv_burst;
        if (stall_left > 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            out_stall  <= 1'b0;
            stall_left <= idle_len(recv_burst);
        end
    end

    // Count cycles in which neither channel moves an item.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no item moved for %0d cycles, %0d results still owed",
                 $time, idle_cycles, outstanding);
        $display("melody_note_sequencer verification failed");
        $finish;
    end

    // Random item of the given action; fields the action ignores get noise.
    function automatic t_in_item any_item(logic [2:0] act);
        t_in_item it;
        it.action        = act;
        it.note_address  = 8'($urandom);
        it.note_length   = 15'($urandom);
        it.note_divider  = 16'($urandom);
        it.start_address = 8'($urandom);
        return it;
    endfunction

    // Note length: mostly a few ticks, rarely up to the full 15 bits.
    function automatic logic [14:0] note_len(int zero_pct);
        int r;
        r = $urandom_range(99);
        if (r < zero_pct) return '0;
        if (r < 90) return 15'($urandom_range(4, 1));
        if (r < 98) return 15'($urandom_range(30, 5));
        return 15'($urandom);
    endfunction

    // Offer one item, hold it until accepted, then idle for a random gap.
    // With no gap, valid stays high straight into the next item.
    task automatic push_item(input t_in_item it);
        int gap;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        action_count[it.action]++;
        if (it.action <= ACT_TONE) items_sent++;
        if ($urandom_range(59) == 0) send_burst = !send_burst;
        gap = idle_len(send_burst);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_cmd(logic [2:0] act, logic [7:0] addr, logic [14:0] len,
                            logic [15:0] div, logic [7:0] start);
        push_item('{action: act, note_address: addr, note_length: len,
                    note_divider: div, start_address: start});
    endtask

    // Drop valid and hold off until every result owed has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    // Write a short melody at a random base, start it and tick it through,
    // with the odd unrelated item mixed into the ticks.
    task automatic play_melody();
        t_in_item   it;
        logic [7:0] base;
        int         n, total, ticks;
        // Bias some bases to the top of the store so the pointer wraps.
        base  = ($urandom_range(4) == 0) ? 8'(8'd255 - $urandom_range(5)) : 8'($urandom);
        n     = $urandom_range(6, 1);
        total = 0;
        for (int k = 0; k < n; k++) begin
            it              = any_item(ACT_WRITE);
            it.note_address = base + 8'(k);
            it.note_length  = note_len(0);
            if ($urandom_range(4) == 0) it.note_divider = '0;
            total += int'(it.note_length);
            push_item(it);
        end
        // Usually close with an end marker; otherwise run into whatever follows.
        if ($urandom_range(3) != 0) begin
            it              = any_item(ACT_WRITE);
            it.note_address = base + 8'(n);
            it.note_length  = '0;
            push_item(it);
        end
        it               = any_item(ACT_START);
        it.start_address = base;
        push_item(it);
        ticks = (total > 40 ? 40 : total) + 2;
        for (int k = 0; k < ticks; k++) begin
            if ($urandom_range(9) == 0) begin
                push_item(any_item(3'($urandom_range(7))));
            end else begin
                push_item(any_item(ACT_TICK));
            end
        end
    endtask

    initial begin
        t_in_item it;
        bit       mid_drain_done;
        mid_drain_done = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: tick with nothing playing, bare tones at the divider extremes.
        send_cmd(ACT_TICK,  8'd0, 15'd0, 16'h0000, 8'd0);
        send_cmd(ACT_TONE,  8'd0, 15'd0, 16'hFFFF, 8'd0);
        send_cmd(ACT_TONE,  8'd0, 15'd0, 16'h0000, 8'd0);
        send_cmd(ACT_TONE,  8'd0, 15'd0, 16'h0001, 8'd0);
        // Store a small melody: plain note, pause, longest note, end marker.
        send_cmd(ACT_WRITE, 8'd0,   15'd3,      16'h1234, 8'd0);
        send_cmd(ACT_WRITE, 8'd1,   15'd1,      16'h0000, 8'd0);
        send_cmd(ACT_WRITE, 8'd2,   15'h7FFF,   16'hFFFF, 8'd0);
        send_cmd(ACT_WRITE, 8'd3,   15'd0,      16'hABCD, 8'd0);
        send_cmd(ACT_WRITE, 8'd255, 15'd2,      16'h8001, 8'd0);
        // Start only records the address; a tone while pending is overridden.
        send_cmd(ACT_START, 8'd0, 15'd0, 16'h0000, 8'd0);
        send_cmd(ACT_TONE,  8'd0, 15'd0, 16'h0100, 8'd0);
        repeat (6) send_cmd(ACT_TICK, 8'd0, 15'd0, 16'h0000, 8'd0);
        // Tone during a running note, then a code the block must ignore.
        send_cmd(ACT_TONE,      8'd0,   15'd0,    16'h0202, 8'd0);
        send_cmd(ACT_UNUSED_LO, 8'd255, 15'h7FFF, 16'hFFFF, 8'd255);
        send_cmd(ACT_STOP,      8'd0,   15'd0,    16'h0000, 8'd0);
        // Melody from the last entry: the pointer wraps to entry 0.
        send_cmd(ACT_START, 8'd0, 15'd0, 16'h0000, 8'd255);
        repeat (3) send_cmd(ACT_TICK, 8'd0, 15'd0, 16'h0000, 8'd0);
        // Melody that begins on its end marker.
        send_cmd(ACT_START,     8'd0,   15'd0,    16'h0000, 8'd3);
        send_cmd(ACT_TICK,      8'd0,   15'd0,    16'h0000, 8'd0);
        send_cmd(ACT_UNUSED_HI, 8'd255, 15'h7FFF, 16'hFFFF, 8'd255);
        send_cmd(ACT_STOP,      8'd255, 15'h7FFF, 16'hFFFF, 8'd255);

        // Hold off the sender until the block has answered everything.
        drain();

        // Fill the whole store so that any start or step reads a written entry.
        for (int a = 0; a < NOTE_DEPTH; a++) begin
            it              = any_item(ACT_WRITE);
            it.note_address = 8'(a);
            it.note_length  = note_len(30);
            if ($urandom_range(6) == 0) it.note_divider = '0;
            push_item(it);
        end

        // Mostly whole melodies, the rest single random items of any code.
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(99) < 60) begin
                play_melody();
            end else begin
                push_item(any_item(3'($urandom_range(7))));
            end
            if (!mid_drain_done && items_sent >= 500) begin
                drain();
                mid_drain_done = 1'b1;
            end
        end

        // Wait for the last results, then let the clock run on for anything stray.
        drain();
        repeat (8) @(posedge clk);

        $display("Sent %0d ticks, %0d note writes, %0d starts, %0d stops, %0d tones, %0d unused",
                 action_count[ACT_TICK], action_count[ACT_WRITE], action_count[ACT_START],
                 action_count[ACT_STOP], action_count[ACT_TONE],
                 action_count[ACT_UNUSED_LO] + action_count[ACT_UNUSED_MID]
                 + action_count[ACT_UNUSED_HI]);
        $display("Checked %0d results: %0d notes loaded, %0d melodies reached an end marker",
                 results_checked, notes_loaded, melodies_ended);
        if (fail_count == 0) begin
            $display("melody_note_sequencer verification clean");
        end else begin
            $display("melody_note_sequencer verification failed");
        end
        $finish;
    end

endmodule

>>> melody_note_sequencer.f
+incdir+rtl
rtl/msq_pkg.sv
rtl/msq_ctrl.sv
rtl/msq_datapath.sv
rtl/melody_note_sequencer.sv
rtl/msq_checker.sv
dv/msq_checker.sv
dv/testbench.sv
